@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL; included by the top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Plain expression checked on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`endif

@@ hw/rtl/pgwf_pkg.sv @@
// Package: constants, types and state codes for the window finder.
package pgwf_pkg;
  localparam int unsigned NUM_W = 31;
  localparam int unsigned WINDOW_MAX_DEF = 65536;
  localparam int unsigned SIEVE_LIMIT_DEF = 46342;
  localparam int unsigned BASE_PRIME_COUNT_DEF = 4792;
  localparam int unsigned PRIME_W = 17;

  typedef enum logic [1:0] {
    ST_PAIRS = 2'd0,
    ST_FEW   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_FILL, S_BASE, S_ROOT, S_START, S_STRIKE,
    S_SCAN, S_SCAN_WAIT, S_DONE, S_OUT
  } state_t;

  // base prime table: build after reset, then serve
  typedef enum logic [2:0] {
    G_CLEAR, G_PRD, G_PCHK, G_STRIKE, G_CRD, G_CCHK, G_SRD, G_SERVE
  } gen_state_t;

  typedef logic [NUM_W-1:0] num_t;
endpackage

@@ hw/rtl/prime_gap_window_finder.sv @@
// Top level: segmented sieve over a query window, then a gap scan.
//
// Usage: present range_low/range_high on the in_ channel (valid/ready).
// After reset the base prime table is built first (sieve clear, strike and
// collect passes); in_ready stays low until it is done.
// in_ready is then high only while the block is idle; one query is worked
// at a time. The answer is held in an output register on the out_ channel
// until out_ready takes it; in_ready stays low until that transfer.
// Sequence: a reversed or too wide window goes from the check straight to
// the output register. Otherwise: the check, a bitwise integer square root
// of high, a fill pass over the bit store, then for each base prime
// p <= sqrt(high) a table read, a 31-step remainder of low mod p, one store
// write per multiple in the window and the loop exit, then a scan pass.
// The next query can be taken the cycle after the result transfer.
// The bit store is a single-port RAM, which sets the rate of fill, strike
// and scan. Reset returns the sequencer to idle; the store needs no clear
// since every query writes each entry before reading it.
module prime_gap_window_finder #(
  parameter int unsigned WINDOW_MAX       = pgwf_pkg::WINDOW_MAX_DEF,
  parameter int unsigned SIEVE_LIMIT      = pgwf_pkg::SIEVE_LIMIT_DEF,
  parameter int unsigned BASE_PRIME_COUNT = pgwf_pkg::BASE_PRIME_COUNT_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [pgwf_pkg::NUM_W-1:0] in_range_low,
  input  logic [pgwf_pkg::NUM_W-1:0] in_range_high,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [pgwf_pkg::NUM_W-1:0] out_near_first,
  output logic [pgwf_pkg::NUM_W-1:0] out_near_second,
  output logic [pgwf_pkg::NUM_W-1:0] out_far_first,
  output logic [pgwf_pkg::NUM_W-1:0] out_far_second
);
  import pgwf_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(WINDOW_MAX);
  localparam int unsigned LW = AW + 1;

  state_t state_r, state_nxt;
  num_t lo_r, lo_nxt, hi_r, hi_nxt;
  logic [LW-1:0] len_r, len_nxt, idx_r, idx_nxt;
  logic [15:0] root_r, root_nxt;
  logic [4:0]  rbit_r, rbit_nxt;
  logic [32:0] j_r, j_nxt;       // current multiple, may exceed 31 bits
  logic [31:0] q_r, q_nxt;       // start search remainder
  logic [4:0]  sh_r, sh_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [LW-1:0] prev_r, prev_nxt, n1_r, n1_nxt, n2_r, n2_nxt, f1_r, f1_nxt, f2_r, f2_nxt;
  logic [LW-1:0] dn_r, dn_nxt, df_r, df_nxt;
  logic [1:0]  st_r, st_nxt;
  num_t onf_r, onf_nxt, ons_r, ons_nxt, off_r, off_nxt, ofs_r, ofs_nxt;
  logic        ov_r, ov_nxt;

  logic           ram_we, ram_wd, ram_rd;
  logic [AW-1:0]  ram_a;
  logic           pg_restart, pg_adv, pg_built, pg_ready, pg_exh;
  logic [PRIME_W-1:0] pg_prime;
  logic [31:0]    p32, rt_try;
  logic [32:0]    width;
  logic [LW-1:0]  gap;

  pgwf_ram #(.WIDTH(1), .DEPTH(WINDOW_MAX)) u_bits (
    .clk(clk), .we(ram_we), .addr(ram_a), .wdata(ram_wd), .rdata(ram_rd)
  );

  pgwf_prime_gen #(
    .SIEVE_LIMIT(SIEVE_LIMIT), .BASE_PRIME_COUNT(BASE_PRIME_COUNT)
  ) u_gen (
    .clk(clk), .rst_n(rst_n), .restart(pg_restart), .advance(pg_adv),
    .built(pg_built), .ready(pg_ready), .prime(pg_prime), .exhausted(pg_exh)
  );

  assign p32    = {15'd0, pg_prime};
  assign rt_try = {16'd0, root_r | (16'd1 << rbit_r)};
  assign width  = {2'd0, hi_r} - {2'd0, lo_r} + 33'd1;
  assign gap    = idx_r - LW'(1) - prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt; hi_r <= hi_nxt; len_r <= len_nxt; idx_r <= idx_nxt;
    root_r <= root_nxt; rbit_r <= rbit_nxt; j_r <= j_nxt; q_r <= q_nxt;
    sh_r <= sh_nxt; cnt_r <= cnt_nxt; prev_r <= prev_nxt;
    n1_r <= n1_nxt; n2_r <= n2_nxt; f1_r <= f1_nxt; f2_r <= f2_nxt;
    dn_r <= dn_nxt; df_r <= df_nxt; st_r <= st_nxt;
    onf_r <= onf_nxt; ons_r <= ons_nxt; off_r <= off_nxt; ofs_r <= ofs_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    lo_nxt = lo_r; hi_nxt = hi_r; len_nxt = len_r; idx_nxt = idx_r;
    root_nxt = root_r; rbit_nxt = rbit_r; j_nxt = j_r; q_nxt = q_r;
    sh_nxt = sh_r; cnt_nxt = cnt_r; prev_nxt = prev_r;
    n1_nxt = n1_r; n2_nxt = n2_r; f1_nxt = f1_r; f2_nxt = f2_r;
    dn_nxt = dn_r; df_nxt = df_r; st_nxt = st_r;
    onf_nxt = onf_r; ons_nxt = ons_r; off_nxt = off_r; ofs_nxt = ofs_r;
    ov_nxt = ov_r;
    ram_we = 1'b0; ram_wd = 1'b0; ram_a = idx_r[AW-1:0];
    pg_restart = 1'b0; pg_adv = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && pg_built) begin
          lo_nxt = in_range_low; hi_nxt = in_range_high;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        onf_nxt = '0; ons_nxt = '0; off_nxt = '0; ofs_nxt = '0;
        if (hi_r < lo_r || width > 33'(WINDOW_MAX)) begin
          st_nxt = ST_RANGE; ov_nxt = 1'b1; state_nxt = S_OUT;
        end else begin
          len_nxt = width[LW-1:0]; idx_nxt = '0;
          root_nxt = '0; rbit_nxt = 5'd15;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        // one bit of the integer square root per cycle
        if (rt_try * rt_try <= {1'b0, hi_r}) root_nxt = rt_try[15:0];
        if (rbit_r == 5'd0) state_nxt = S_FILL;
        else rbit_nxt = rbit_r - 5'd1;
      end
      S_FILL: begin
        ram_we = 1'b1;
        ram_wd = ({1'b0, lo_r} + 32'(idx_r)) >= 32'd2;
        idx_nxt = idx_r + LW'(1);
        if (idx_r + LW'(1) == len_r) begin
          pg_restart = 1'b1; state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        if (pg_ready) begin
          if (pg_exh || p32 > {16'd0, root_r}) begin
            idx_nxt = '0; cnt_nxt = '0; prev_nxt = '0;
            state_nxt = S_SCAN;
          end else begin
            // remainder of lo mod p: shift-subtract, 31 steps
            q_nxt = '0; sh_nxt = 5'd30;
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        q_nxt = {q_r[30:0], lo_r[sh_r]};
        if ({q_r[30:0], lo_r[sh_r]} >= p32) q_nxt = {q_r[30:0], lo_r[sh_r]} - p32;
        if (sh_r == 5'd0) begin
          // j = lo rounded up to a multiple of p, but 2p where that multiple is p
          if (q_nxt == 32'd0) j_nxt = {2'd0, lo_r};
          else j_nxt = {2'd0, lo_r} + 33'(p32 - q_nxt);
          if (q_nxt == 32'd0 && {1'b0, lo_r} == p32) j_nxt = {2'd0, lo_r} + 33'(p32);
          if (q_nxt != 32'd0 && 33'({2'd0, lo_r} + 33'(p32 - q_nxt)) == 33'(p32))
            j_nxt = 33'(p32) + 33'(p32);
          state_nxt = S_STRIKE;
        end else sh_nxt = sh_r - 5'd1;
      end
      S_STRIKE: begin
        if (j_r > {2'd0, hi_r}) begin
          pg_adv = 1'b1; state_nxt = S_BASE;
        end else begin
          ram_we = 1'b1; ram_wd = 1'b0;
          ram_a = AW'(j_r - {2'd0, lo_r});
          j_nxt = j_r + 33'(p32);
        end
      end
      S_SCAN: begin
        // read address idx_r; data arrives next cycle for idx_r-1
        idx_nxt = idx_r + LW'(1);
        state_nxt = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        if (ram_rd) begin
          if (cnt_r == 2'd1) begin
            n1_nxt = prev_r; f1_nxt = prev_r;
            n2_nxt = idx_r - LW'(1); f2_nxt = idx_r - LW'(1);
            dn_nxt = gap; df_nxt = gap;
          end else if (cnt_r == 2'd2) begin
            if (gap > df_r) begin
              df_nxt = gap; f1_nxt = prev_r; f2_nxt = idx_r - LW'(1);
            end
            if (gap < dn_r) begin
              dn_nxt = gap; n1_nxt = prev_r; n2_nxt = idx_r - LW'(1);
            end
          end
          if (cnt_r != 2'd2) cnt_nxt = cnt_r + 2'd1;
          prev_nxt = idx_r - LW'(1);
        end
        if (idx_r == len_r) state_nxt = S_DONE;
        else begin
          idx_nxt = idx_r + LW'(1);
        end
      end
      S_DONE: begin
        if (cnt_r != 2'd2) st_nxt = ST_FEW;
        else begin
          st_nxt = ST_PAIRS;
          onf_nxt = NUM_W'({1'b0, lo_r} + 32'(n1_r));
          ons_nxt = NUM_W'({1'b0, lo_r} + 32'(n2_r));
          off_nxt = NUM_W'({1'b0, lo_r} + 32'(f1_r));
          ofs_nxt = NUM_W'({1'b0, lo_r} + 32'(f2_r));
        end
        ov_nxt = 1'b1; state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          ov_nxt = 1'b0; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready        = (state_r == S_IDLE) && pg_built;
  assign out_valid       = ov_r;
  assign out_status      = st_r;
  assign out_near_first  = onf_r;
  assign out_near_second = ons_r;
  assign out_far_first   = off_r;
  assign out_far_second  = ofs_r;

  `ASSERT_ALWAYS(a_valid_in_out, clk, rst_n, ov_r == (state_r == S_OUT), "valid outside OUT")
  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, ov_r |-> !in_ready, "accept while result pending")
  `ASSERT_IMPL(a_status_range, clk, rst_n, ov_r |-> (st_r != 2'd3), "bad status code")
endmodule

@@ hw/rtl/pgwf_ram.sv @@
// Generic single-port RAM with registered read.
module pgwf_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ hw/rtl/pgwf_prime_gen.sv @@
// Base prime table: sieved into a RAM after reset, then served in ascending order.
module pgwf_prime_gen #(
  parameter int unsigned SIEVE_LIMIT      = pgwf_pkg::SIEVE_LIMIT_DEF,
  parameter int unsigned BASE_PRIME_COUNT = pgwf_pkg::BASE_PRIME_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic                          advance,
  output logic                          built,
  output logic                          ready,
  output logic [pgwf_pkg::PRIME_W-1:0]  prime,
  output logic                          exhausted
);
  import pgwf_pkg::*;

  localparam int unsigned SW = $clog2(SIEVE_LIMIT + 1);
  localparam int unsigned IW = SW + 1;
  localparam int unsigned TA = $clog2(BASE_PRIME_COUNT);
  localparam int unsigned TW = $clog2(BASE_PRIME_COUNT + 1);

  gen_state_t gst_r, gst_nxt;
  logic [IW-1:0] i_r, i_nxt;        // sieve index or current multiple
  logic [8:0]    p_r, p_nxt;        // sieving prime, p*p <= SIEVE_LIMIT
  logic [TW-1:0] k_r, k_nxt, fill_r, fill_nxt;
  logic [17:0]   psq;

  logic          sv_we, sv_wd, sv_rd;
  logic [SW-1:0] sv_a;
  logic          tb_we;
  logic [TA-1:0] tb_a;
  logic [15:0]   tb_wd, tb_rd;

  // mark 1 = composite
  pgwf_ram #(.WIDTH(1), .DEPTH(SIEVE_LIMIT + 1)) u_sieve (
    .clk(clk), .we(sv_we), .addr(sv_a), .wdata(sv_wd), .rdata(sv_rd)
  );

  pgwf_ram #(.WIDTH(16), .DEPTH(BASE_PRIME_COUNT)) u_table (
    .clk(clk), .we(tb_we), .addr(tb_a), .wdata(tb_wd), .rdata(tb_rd)
  );

  assign psq = 18'(p_r) * 18'(p_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gst_r  <= G_CLEAR;
      i_r    <= '0;
      p_r    <= 9'd2;
      k_r    <= '0;
      fill_r <= '0;
    end else begin
      gst_r  <= gst_nxt;
      i_r    <= i_nxt;
      p_r    <= p_nxt;
      k_r    <= k_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_comb begin
    gst_nxt = gst_r; i_nxt = i_r; p_nxt = p_r; k_nxt = k_r; fill_nxt = fill_r;
    sv_we = 1'b0; sv_wd = 1'b0; sv_a = i_r[SW-1:0];
    tb_we = 1'b0; tb_a = k_r[TA-1:0]; tb_wd = i_r[15:0];
    unique case (gst_r)
      G_CLEAR: begin
        sv_we = 1'b1;
        if (i_r == IW'(SIEVE_LIMIT)) begin
          p_nxt = 9'd2; gst_nxt = G_PRD;
        end else i_nxt = i_r + IW'(1);
      end
      G_PRD: begin
        sv_a = SW'(p_r);
        if (psq > 18'(SIEVE_LIMIT)) begin
          i_nxt = IW'(2); fill_nxt = '0; gst_nxt = G_CRD;
        end else gst_nxt = G_PCHK;
      end
      G_PCHK: begin
        sv_a = SW'(p_r);
        if (sv_rd) begin
          p_nxt = p_r + 9'd1; gst_nxt = G_PRD;
        end else begin
          i_nxt = IW'(psq); gst_nxt = G_STRIKE;
        end
      end
      G_STRIKE: begin
        if (i_r > IW'(SIEVE_LIMIT)) begin
          p_nxt = p_r + 9'd1; gst_nxt = G_PRD;
        end else begin
          sv_we = 1'b1; sv_wd = 1'b1;
          i_nxt = i_r + IW'(p_r);
        end
      end
      G_CRD: gst_nxt = G_CCHK;
      G_CCHK: begin
        if (!sv_rd && fill_r != TW'(BASE_PRIME_COUNT)) begin
          tb_we = 1'b1; tb_a = fill_r[TA-1:0];
          fill_nxt = fill_r + TW'(1);
        end
        if (i_r == IW'(SIEVE_LIMIT)) begin
          k_nxt = '0; gst_nxt = G_SRD;
        end else begin
          i_nxt = i_r + IW'(1); gst_nxt = G_CRD;
        end
      end
      G_SRD: begin
        if (restart) k_nxt = '0;
        else gst_nxt = G_SERVE;
      end
      G_SERVE: begin
        if (restart) begin
          k_nxt = '0; gst_nxt = G_SRD;
        end else if (advance) begin
          k_nxt = k_r + TW'(1); gst_nxt = G_SRD;
        end
      end
      default: gst_nxt = G_CLEAR;
    endcase
  end

  assign built     = (gst_r == G_SRD) || (gst_r == G_SERVE);
  assign ready     = (gst_r == G_SERVE);
  assign exhausted = (k_r >= fill_r);
  assign prime     = exhausted ? '0 : PRIME_W'(tb_rd);
endmodule
